// ===== sv/dmsce_pkg.sv =====
// shared constants, types and speed scaling for the dual motor command encoder
package dmsce_pkg;

  localparam logic [2:0] CMD_STOP_ALL = 3'd0;
  localparam logic [2:0] CMD_FORWARD  = 3'd1;
  localparam logic [2:0] CMD_BACKWARD = 3'd2;
  localparam logic [2:0] CMD_LEFT     = 3'd3;
  localparam logic [2:0] CMD_RIGHT    = 3'd4;
  localparam logic [2:0] CMD_TICK     = 3'd5;

  localparam logic [7:0] STOP_ALL_BYTE = 8'd0;
  localparam logic [7:0] M1_STOP_BYTE  = 8'd64;
  localparam logic [7:0] M2_STOP_BYTE  = 8'd192;
  localparam logic [7:0] M1_FWD_BASE   = 8'd63;
  localparam logic [7:0] M1_REV_BASE   = 8'd65;
  localparam logic [7:0] M2_FWD_BASE   = 8'd193;
  localparam logic [7:0] M2_REV_BASE   = 8'd191;

  localparam logic [5:0] SPAN_62 = 6'd62;
  localparam logic [5:0] SPAN_63 = 6'd63;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // request results: b0 goes first when v0 is set, b1 is always the final byte
  typedef struct packed {
    logic       v0;
    logic       v1;
    logic [7:0] b0;
    logic [7:0] b1;
  } pair_t;

  // floor(x * k / 255) via reciprocal form, exact for products below 2^16
  function automatic logic [5:0] scale_div255(input logic [7:0] x, input logic [5:0] k);
    logic [13:0] p;
    logic [14:0] s;
    p = 14'(x) * 14'(k);
    s = {1'b0, p} + 15'(p[13:8]) + 15'd1;
    return s[13:8];
  endfunction

endpackage

// ===== sv/dual_motor_serial_command_encoder.sv =====
// top level: input register, timeout register, motor logic and result register
// a request goes via the input register, then the result register sends its bytes
// throughput: one request per cycle while out_ready is high and each gives at most
//   one byte; a two-byte request holds the result register, one byte per cycle
// reset (rst_n low, synchronous): both motors stopped, counters zero, timeout 500,
//   input and result registers empty
module dual_motor_serial_command_encoder #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_speed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import dmsce_pkg::*;

  logic        s1_v_r;
  logic [2:0]  cmd_r;
  logic [7:0]  speed_r;
  logic [15:0] timeout_r;
  logic        can_load;
  logic        load;
  pair_t       pair;

  assign load     = s1_v_r && can_load;
  assign in_ready = !s1_v_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        s1_v_r  <= 1'b1;
        cmd_r   <= in_command;
        speed_r <= in_speed;
      end else if (load) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  dmsce_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .cmd     (cmd_r),
    .speed   (speed_r),
    .timeout (timeout_r),
    .pair    (pair)
  );

  dmsce_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .pair_in     (pair),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !can_load |=> s1_v_r) else $error("held request dropped");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready) else $error("empty input register not ready");
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r) else $error("accepted request not captured");

endmodule

// ===== sv/dmsce_core.sv =====
// motor state and byte generation for one request
module dmsce_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [2:0]        cmd,
  input  logic [7:0]        speed,
  input  logic [15:0]       timeout,
  output dmsce_pkg::pair_t  pair
);
  import dmsce_pkg::*;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  m1_run_r, m1_run_nxt;
  logic                  m2_run_r, m2_run_nxt;
  logic [TIMER_BITS-1:0] m1_el_r, m1_el_nxt;
  logic [TIMER_BITS-1:0] m2_el_r, m2_el_nxt;
  logic [TIMER_BITS-1:0] m1_inc, m2_inc;
  logic                  m1_to, m2_to;
  logic                  rev1, rev2;
  logic [5:0]            q62, q63;
  logic [7:0]            m1_code, m2_code;

  assign m1_inc = (m1_el_r == '1) ? m1_el_r : m1_el_r + 1'b1;
  assign m2_inc = (m2_el_r == '1) ? m2_el_r : m2_el_r + 1'b1;
  assign m1_to  = m1_run_r && (CW'(m1_inc) > CW'(timeout));
  assign m2_to  = m2_run_r && (CW'(m2_inc) > CW'(timeout));

  assign rev1 = (cmd == CMD_BACKWARD) || (cmd == CMD_RIGHT);
  assign rev2 = (cmd == CMD_BACKWARD) || (cmd == CMD_LEFT);
  assign q62  = scale_div255(speed, SPAN_62);
  assign q63  = scale_div255(speed, SPAN_63);
  assign m1_code = rev1 ? M1_REV_BASE + {2'b00, q62} : M1_FWD_BASE - {2'b00, q62};
  assign m2_code = rev2 ? M2_REV_BASE - {2'b00, q63} : M2_FWD_BASE + {2'b00, q62};

  always_comb begin
    m1_run_nxt = m1_run_r;
    m2_run_nxt = m2_run_r;
    m1_el_nxt  = m1_el_r;
    m2_el_nxt  = m2_el_r;
    pair       = '0;
    case (cmd)
      CMD_STOP_ALL: begin
        m1_run_nxt = 1'b0;
        m2_run_nxt = 1'b0;
        m1_el_nxt  = '0;
        m2_el_nxt  = '0;
        pair.v1    = 1'b1;
        pair.b1    = STOP_ALL_BYTE;
      end
      CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT: begin
        m1_el_nxt = '0;
        m2_el_nxt = '0;
        pair.v0   = 1'b1;
        pair.v1   = 1'b1;
        if (speed == 8'd0) begin
          m1_run_nxt = 1'b0;
          m2_run_nxt = 1'b0;
          pair.b0    = M1_STOP_BYTE;
          pair.b1    = M2_STOP_BYTE;
        end else begin
          m1_run_nxt = 1'b1;
          m2_run_nxt = 1'b1;
          pair.b0    = m1_code;
          pair.b1    = m2_code;
        end
      end
      CMD_TICK: begin
        if (!m1_run_r || m1_to) begin
          m1_el_nxt  = '0;
          m1_run_nxt = 1'b0;
        end else begin
          m1_el_nxt = m1_inc;
        end
        if (!m2_run_r || m2_to) begin
          m2_el_nxt  = '0;
          m2_run_nxt = 1'b0;
        end else begin
          m2_el_nxt = m2_inc;
        end
        if (m1_to && m2_to) begin
          pair.v0 = 1'b1;
          pair.b0 = M1_STOP_BYTE;
          pair.v1 = 1'b1;
          pair.b1 = M2_STOP_BYTE;
        end else if (m1_to) begin
          pair.v1 = 1'b1;
          pair.b1 = M1_STOP_BYTE;
        end else if (m2_to) begin
          pair.v1 = 1'b1;
          pair.b1 = M2_STOP_BYTE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_run_r <= 1'b0;
      m2_run_r <= 1'b0;
      m1_el_r  <= '0;
      m2_el_r  <= '0;
    end else if (load) begin
      m1_run_r <= m1_run_nxt;
      m2_run_r <= m2_run_nxt;
      m1_el_r  <= m1_el_nxt;
      m2_el_r  <= m2_el_nxt;
    end
  end

  a_m1_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !m1_run_r |-> m1_el_r == '0) else $error("motor 1 counter runs while stopped");
  a_m2_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !m2_run_r |-> m2_el_r == '0) else $error("motor 2 counter runs while stopped");
  a_stop_all: assert property (@(posedge clk) disable iff (!rst_n)
    load && cmd == CMD_STOP_ALL |=> !m1_run_r && !m2_run_r)
    else $error("stop all left a motor running");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(m1_el_r) && $stable(m2_el_r))
    else $error("counter moved without a request");

endmodule

// ===== sv/dmsce_out.sv =====
// result register that sends up to two bytes per request
module dmsce_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dmsce_pkg::pair_t pair_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);
  import dmsce_pkg::*;

  logic       v0_r, v1_r;
  logic [7:0] b0_r, b1_r;
  logic       take;

  assign out_valid   = v0_r || v1_r;
  assign out_tx_byte = v0_r ? b0_r : b1_r;
  assign out_last    = !v0_r;
  assign take        = out_valid && out_ready;
  assign can_load    = !out_valid || (out_ready && !v0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (load) begin
      v0_r <= pair_in.v0;
      v1_r <= pair_in.v1;
      b0_r <= pair_in.b0;
      b1_r <= pair_in.b1;
    end else if (take) begin
      if (v0_r) begin
        v0_r <= 1'b0;
      end else begin
        v1_r <= 1'b0;
      end
    end
  end

  a_first_has_final: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> v1_r) else $error("first byte held without a final byte");
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load) else $error("result register overwritten");
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take && v0_r |=> v1_r && !v0_r) else $error("final byte lost after first");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the dual motor serial command encoder with a cycle-free predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmsce_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int DRAIN_PAD = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int REPORT_CAP = 20;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } serial_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_STOP_ALL;
  logic [7:0]  in_speed = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  serial_byte_t pending_bytes[$];

  logic        m1_on = 1'b0;
  logic        m2_on = 1'b0;
  logic [15:0] m1_ticks = 16'd0;
  logic [15:0] m2_ticks = 16'd0;
  logic [15:0] timeout_limit = TIMEOUT_RESET;

  int in_idle_pct = 25;
  int out_idle_pct = 25;
  logic hold_req = 1'b0;
  logic stall_rx = 1'b0;

  int mismatches = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int timeout_stops = 0;

  dual_motor_serial_command_encoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_speed    (in_speed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] motor_one_code(input logic [7:0] x, input bit rev);
    int unsigned step;
    step = int'(x) * int'(SPAN_62) / 255;
    return rev ? M1_REV_BASE + 8'(step) : M1_FWD_BASE - 8'(step);
  endfunction

  function automatic logic [7:0] motor_two_code(input logic [7:0] x, input bit rev);
    int unsigned step;
    if (rev) begin
      step = int'(x) * int'(SPAN_63) / 255;
      return M2_REV_BASE - 8'(step);
    end
    step = int'(x) * int'(SPAN_62) / 255;
    return M2_FWD_BASE + 8'(step);
  endfunction

  function automatic bit motor_times_out(inout logic on, inout logic [15:0] ticks);
    if (!on) begin
      ticks = 16'd0;
      return 1'b0;
    end
    if (ticks != 16'hffff) ticks = ticks + 16'd1;
    if (ticks > timeout_limit) begin
      on = 1'b0;
      ticks = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_byte(input logic [7:0] tx, input logic last);
    serial_byte_t b;
    b.tx = tx;
    b.last = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic void predict_request(input logic [2:0] cmd, input logic [7:0] spd);
    logic [7:0] stops[$];
    bit rev1;
    bit rev2;
    case (cmd)
      CMD_STOP_ALL: begin
        m1_on = 1'b0;
        m2_on = 1'b0;
        m1_ticks = 16'd0;
        m2_ticks = 16'd0;
        queue_byte(STOP_ALL_BYTE, 1'b1);
      end
      CMD_TICK: begin
        if (motor_times_out(m1_on, m1_ticks)) stops.push_back(M1_STOP_BYTE);
        if (motor_times_out(m2_on, m2_ticks)) stops.push_back(M2_STOP_BYTE);
        foreach (stops[i]) queue_byte(stops[i], i == stops.size() - 1);
        timeout_stops += stops.size();
      end
      CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT: begin
        rev1 = (cmd == CMD_BACKWARD) || (cmd == CMD_RIGHT);
        rev2 = (cmd == CMD_BACKWARD) || (cmd == CMD_LEFT);
        m1_ticks = 16'd0;
        m2_ticks = 16'd0;
        m1_on = spd != 8'd0;
        m2_on = spd != 8'd0;
        queue_byte(spd == 8'd0 ? M1_STOP_BYTE : motor_one_code(spd, rev1), 1'b0);
        queue_byte(spd == 8'd0 ? M2_STOP_BYTE : motor_two_code(spd, rev2), 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_CAP)
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // receiver: random ready, forced low while a hold is running
  always @(posedge clk) begin
    if (stall_rx) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= out_idle_pct;
    end
  end

  always begin
    wait (hold_req);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_rx <= 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk) begin
    serial_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_tx_byte, -1);
      end else begin
        want = pending_bytes.pop_front();
        if (out_tx_byte !== want.tx) report_mismatch("tx_byte", out_tx_byte, want.tx);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] spd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_speed <= spd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, spd);
    if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_limit = value;
  endtask

  task automatic send_random_request();
    int pick;
    logic [2:0] cmd;
    logic [7:0] spd;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_TICK;
    else if (pick < 85) cmd = 3'($urandom_range(CMD_RIGHT, CMD_FORWARD));
    else if (pick < 93) cmd = CMD_STOP_ALL;
    else cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    pick = $urandom_range(9);
    spd = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    send_request(cmd, spd);
  endtask

  // timeout after reset must be the default
  task automatic test_reset_timeout();
    send_request(CMD_FORWARD, 8'd200);
    repeat (int'(TIMEOUT_RESET) + 1) send_request(CMD_TICK, 8'($urandom));
  endtask

  task automatic test_directed();
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_FORWARD, 8'd0);
    send_request(CMD_FORWARD, 8'd1);
    send_request(CMD_FORWARD, 8'd255);
    send_request(CMD_BACKWARD, 8'd255);
    send_request(CMD_BACKWARD, 8'd128);
    send_request(CMD_BACKWARD, 8'd1);
    send_request(CMD_LEFT, 8'd254);
    send_request(CMD_LEFT, 8'd0);
    send_request(CMD_LEFT, 8'd255);
    send_request(CMD_RIGHT, 8'd255);
    send_request(CMD_RIGHT, 8'd85);
    send_request(CMD_SPARE_6, 8'd255);
    send_request(CMD_SPARE_7, 8'd170);
    send_request(CMD_TICK, 8'd255);
    send_request(CMD_STOP_ALL, 8'd255);
    send_request(CMD_TICK, 8'd85);
    send_request(CMD_STOP_ALL, 8'd0);
  endtask

  task automatic test_short_timeouts();
    set_timeout(16'd0);
    send_request(CMD_LEFT, 8'd77);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_TICK, 8'd0);
    set_timeout(16'd1);
    send_request(CMD_RIGHT, 8'd33);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_BACKWARD, 8'd9);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_FORWARD, 8'd0);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_TICK, 8'd0);
  endtask

  task automatic test_backpressure();
    set_timeout(16'd4);
    hold_req = 1'b1;
    repeat (40) send_random_request();
  endtask

  task automatic test_random();
    logic [15:0] limits[6];
    int left;
    limits[0] = 16'd0;
    limits[1] = 16'd3;
    limits[2] = 16'($urandom_range(10, 2));
    limits[3] = 16'hffff;
    limits[4] = 16'($urandom);
    limits[5] = 16'($urandom_range(8, 1));
    foreach (limits[p]) begin
      set_timeout(limits[p]);
      if (p == 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 25;
        out_idle_pct = 25;
      end
      left = 140;
      while (left > 0) begin
        send_random_request();
        if (in_command != CMD_SPARE_6 && in_command != CMD_SPARE_7) left--;
      end
    end
    in_idle_pct = 25;
    out_idle_pct = 25;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_timeout();
    test_directed();
    test_short_timeouts();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    for (int n = 0; n < 10000 && pending_bytes.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_bytes.size() != 0) report_mismatch("bytes never sent", 0, pending_bytes.size());
    $display("tb: %0d requests over the default and six other timeouts plus back-pressure",
             requests_sent);
    $display("tb: %0d bytes checked, %0d timeout stops", bytes_checked, timeout_stops);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
